/* sv/gsp_pkg.sv */
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared constants, command codes and control types of the slot pool.
// ----------------------------------------------------------------------------
package gsp_pkg;

  localparam int SLOT_COUNT_DEF = 16;

  localparam logic [31:0] SEED_MUL = 32'h9E3779B9;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 88;

  localparam logic [2:0] MODE_CREATE      = 3'd0;
  localparam logic [2:0] MODE_PLAY        = 3'd1;
  localparam logic [2:0] MODE_STOP        = 3'd2;
  localparam logic [2:0] MODE_REPLAY      = 3'd3;
  localparam logic [2:0] MODE_DESTROY     = 3'd4;
  localparam logic [2:0] MODE_QUERY       = 3'd5;
  localparam logic [2:0] MODE_TICK        = 3'd6;
  localparam logic [2:0] MODE_DESTROY_ALL = 3'd7;

  typedef struct packed {
    logic accept;
    logic exec;
    logic load_out;
  } ctrl_cmd_t;

endpackage

/* sv/gsp_ctrl.sv */
// ----------------------------------------------------------------------------
// gsp_ctrl
// Sequencer of the slot pool: accepts one item, steps the datapath through
// the update and count cycles, and owns the output valid flag.
// ----------------------------------------------------------------------------
module gsp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output gsp_pkg::ctrl_cmd_t  cmd
);
  import gsp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign s_tready     = (state == ST_IDLE);
  assign out_free     = !m_tvalid || m_tready;
  assign cmd.accept   = s_tvalid && s_tready;
  assign cmd.exec     = (state == ST_EXEC);
  assign cmd.load_out = (state == ST_DONE) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

/* sv/gsp_datapath.sv */
// ----------------------------------------------------------------------------
// gsp_datapath
// Slot flags, id memory, allocation search, seed multiplier and the output
// register of the slot pool.
// ----------------------------------------------------------------------------
module gsp_datapath #(
  parameter int SLOT_COUNT = gsp_pkg::SLOT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  gsp_pkg::ctrl_cmd_t              cmd,
  input  logic [gsp_pkg::IN_DATA_W-1:0]   in_data,
  input  logic [gsp_pkg::IN_USER_W-1:0]   in_user,
  output logic [gsp_pkg::OUT_DATA_W-1:0]  out_data
);
  import gsp_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  logic [15:0]           id_mem [SLOT_COUNT];
  logic [15:0]           rd_id;

  logic [2:0]            mode;
  logic [7:0]            idx;
  logic [15:0]           hid;
  logic                  def_present;
  logic                  continuous;
  logic [15:0]           fin;

  logic [SLOT_COUNT-1:0] used;
  logic [SLOT_COUNT-1:0] playing;
  logic [SLOT_COUNT-1:0] owned;
  logic [SLOT_COUNT-1:0] cont;
  logic [15:0]           next_id;

  logic [SLOT_COUNT-1:0] used_next;
  logic [SLOT_COUNT-1:0] playing_next;
  logic [SLOT_COUNT-1:0] owned_next;
  logic [SLOT_COUNT-1:0] cont_next;
  logic [15:0]           next_id_next;

  logic                  ok;
  logic [3:0]            oslot;
  logic [15:0]           oid;
  logic [31:0]           seed;
  logic                  qplay;
  logic                  qown;
  logic                  restart;
  logic [15:0]           freed16;

  logic                  ok_next;
  logic [3:0]            oslot_next;
  logic [15:0]           oid_next;
  logic [31:0]           seed_next;
  logic                  qplay_next;
  logic                  qown_next;
  logic                  restart_next;
  logic [15:0]           freed16_next;

  logic [IDX_W-1:0]      alloc_idx;
  logic                  found;
  logic                  do_alloc;
  logic [IDX_W-1:0]      hidx;
  logic                  hvalid;
  logic [31:0]           prod;
  logic [16:0]           id_inc;
  logic [SLOT_COUNT-1:0] freeing;
  logic [SLOT_COUNT-1:0] freed;
  logic [SLOT_COUNT+15:0] fin_pad;
  logic [SLOT_COUNT-1:0] fin_vec;
  logic [SLOT_COUNT+15:0] freed_pad;
  logic [CNT_W-1:0]      alive;
  logic [CNT_W-1:0]      active;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode        <= in_user[2:0];
      idx         <= in_data[7:0];
      hid         <= in_data[23:8];
      def_present <= in_data[24];
      continuous  <= in_data[25];
      fin         <= in_data[41:26];
      rd_id       <= id_mem[in_data[IDX_W-1:0]];
    end
    if (cmd.exec && do_alloc) begin
      id_mem[alloc_idx] <= next_id;
    end
  end

  always_comb begin
    alloc_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used[i]) begin
        alloc_idx = IDX_W'(i);
      end
    end
  end

  assign found    = !(&used);
  assign do_alloc = (mode == MODE_CREATE || mode == MODE_PLAY) && def_present && found;
  assign hidx     = idx[IDX_W-1:0];
  assign hvalid   = (idx < 8'(SLOT_COUNT)) && (hid != 16'd0) && used[hidx]
                    && (rd_id == hid);
  assign prod     = 32'(next_id) * SEED_MUL;
  assign id_inc   = {1'b0, next_id} + 17'd1;
  assign freeing  = used & ~playing & ~owned;
  assign fin_pad  = {{SLOT_COUNT{1'b0}}, fin};
  assign fin_vec  = fin_pad[SLOT_COUNT-1:0];
  assign freed_pad = {16'd0, freed};

  always_comb begin
    used_next     = used;
    playing_next  = playing;
    owned_next    = owned;
    cont_next     = cont;
    next_id_next  = next_id;
    ok_next       = 1'b0;
    oslot_next    = '0;
    oid_next      = '0;
    seed_next     = '0;
    qplay_next    = 1'b0;
    qown_next     = 1'b0;
    restart_next  = 1'b0;
    freed         = '0;
    unique case (mode)
      MODE_CREATE, MODE_PLAY: begin
        if (do_alloc) begin
          used_next[alloc_idx]    = 1'b1;
          cont_next[alloc_idx]    = continuous;
          owned_next[alloc_idx]   = (mode == MODE_CREATE);
          playing_next[alloc_idx] = (mode == MODE_PLAY);
          next_id_next = (id_inc[15:0] == 16'd0) ? 16'd1 : id_inc[15:0];
          ok_next      = 1'b1;
          oslot_next   = 4'(alloc_idx);
          oid_next     = next_id;
          seed_next    = prod;
        end
      end
      MODE_STOP: begin
        if (hvalid) begin
          ok_next             = 1'b1;
          playing_next[hidx]  = 1'b0;
        end
      end
      MODE_REPLAY: begin
        if (hvalid) begin
          ok_next             = 1'b1;
          playing_next[hidx]  = 1'b1;
          restart_next        = 1'b1;
        end
      end
      MODE_DESTROY: begin
        if (hvalid) begin
          ok_next           = 1'b1;
          owned_next[hidx]  = 1'b0;
          if (cont[hidx]) begin
            playing_next[hidx] = 1'b0;
          end
        end
      end
      MODE_QUERY: begin
        if (hvalid) begin
          ok_next    = 1'b1;
          qplay_next = playing[hidx];
          qown_next  = owned[hidx];
        end
      end
      MODE_TICK: begin
        freed        = freeing;
        used_next    = used & ~freeing;
        owned_next   = owned & ~freeing;
        playing_next = playing & ~freeing & ~(used & fin_vec);
      end
      MODE_DESTROY_ALL: begin
        freed        = used;
        used_next    = '0;
        owned_next   = '0;
        playing_next = '0;
      end
      default: begin
        freed = '0;
      end
    endcase
    freed16_next = freed_pad[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      playing <= '0;
      owned   <= '0;
      cont    <= '0;
      next_id <= 16'd1;
    end else if (cmd.exec) begin
      used    <= used_next;
      playing <= playing_next;
      owned   <= owned_next;
      cont    <= cont_next;
      next_id <= next_id_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok      <= ok_next;
      oslot   <= oslot_next;
      oid     <= oid_next;
      seed    <= seed_next;
      qplay   <= qplay_next;
      qown    <= qown_next;
      restart <= restart_next;
      freed16 <= freed16_next;
    end
  end

  always_comb begin
    alive  = '0;
    active = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      alive  = alive + CNT_W'(used[i]);
      active = active + CNT_W'(used[i] & playing[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {6'd0, freed16, 5'(active), 5'(alive), restart, qown, qplay,
                   seed, oid, oslot, ok};
    end
  end

endmodule

/* sv/generational_slot_pool.sv */
// ----------------------------------------------------------------------------
// generational_slot_pool
// Pool of slots handed out through generational handles (slot plus id).
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// s_*      in         s_tvalid / s_tready  tuser: mode; tdata: handle, flags, mask
// m_*      out        m_tvalid / m_tready  tdata: status, allocation, counts, mask
//
// Each item steps through the accept with the id memory read, the state
// update with the seed multiply, then the slot count and the output load.
// A new item is accepted while a finished result waits in the output register.
// A stalled output holds the next result in the count cycle.
// Reset is synchronous and empties the pool; the id memory needs no clearing.
// ----------------------------------------------------------------------------
module generational_slot_pool #(
  parameter int SLOT_COUNT = gsp_pkg::SLOT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [7:0] slot_index, [23:8] handle_id, [24] def_present, [25] continuous,
  // [41:26] finished_mask
  input  logic [gsp_pkg::IN_DATA_W-1:0]   s_tdata,
  // [2:0] mode
  input  logic [gsp_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] ok, [4:1] out_slot, [20:5] out_handle_id, [52:21] seed, [53] is_playing,
  // [54] is_owned, [55] restart, [60:56] alive_count, [65:61] active_count,
  // [81:66] freed_mask
  output logic [gsp_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import gsp_pkg::*;

  ctrl_cmd_t cmd;

  gsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  gsp_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (s_tdata),
    .in_user  (s_tuser),
    .out_data (m_tdata)
  );

endmodule

/* sv/gsp_checker.sv */
// ----------------------------------------------------------------------------
// gsp_checker
// Port-level checks of the slot pool, bound to the top level.
// ----------------------------------------------------------------------------
module gsp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [gsp_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import gsp_pkg::*;

  // One item is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while another is in work");

  // Every accepted item is followed by a valid result on the output.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> ##3 m_tvalid)
    else $error("result missing after an accepted item");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_active_le_alive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[65:61] <= m_tdata[60:56]))
    else $error("active count exceeds alive count");

  // A result without success carries no allocation.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[52:1] == 52'd0))
    else $error("allocation fields set on a failed item");

endmodule

bind generational_slot_pool gsp_checker u_gsp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
